/* sv/sorted_insert_priority_queue_macros.svh */
// assertion macros for the sorted insert priority queue
`ifndef SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SIQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SIQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/siq_pkg.sv */
`default_nettype none
package siq_pkg;

    localparam int TAG_W  = 16;
    localparam int PRIO_W = 16;
    localparam int STAT_W = 2;

    localparam logic MODE_INSERT   = 1'b0;
    localparam logic MODE_TRAVERSE = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_DROPPED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ENTRY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [TAG_W-1:0]         tag;
        logic signed [PRIO_W-1:0] prio;
    } entry_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic   ins;
        logic   rot;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage
`default_nettype wire

/* sv/siq_cell.sv */
`default_nettype none
module siq_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire siq_pkg::cell_ctrl_t ctrl,
    input  wire logic               left_keep,
    input  wire logic               left_valid,
    input  wire siq_pkg::entry_t    left_entry,
    input  wire logic               right_valid,
    input  wire siq_pkg::entry_t    right_entry,
    input  wire siq_pkg::entry_t    head_entry,
    output logic                    keep,
    output logic                    valid,
    output siq_pkg::entry_t         entry
);

    logic            valid_reg;
    logic            valid_next;
    siq_pkg::entry_t entry_reg;
    siq_pkg::entry_t entry_next;

    // entry stays put when its priority is not below the newcomer
    assign keep  = valid_reg && (entry_reg.prio >= ctrl.new_entry.prio);
    assign valid = valid_reg;
    assign entry = entry_reg;

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            valid_next = valid_reg | left_valid;
            if (!keep)
            begin
                // first cell past the kept ones takes the newcomer, the rest shift along
                entry_next = left_keep ? ctrl.new_entry : left_entry;
            end
        end
        else if (ctrl.rot && valid_reg)
        begin
            // rotate towards the head, last valid cell wraps round to the head
            entry_next = right_valid ? right_entry : head_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
`default_nettype wire

/* sv/sorted_insert_priority_queue.sv */
// result: an insert or an empty readout gives its single registered result in the cycle after its transfer
// readout: n stored entries leave one per cycle while the output is free, the chain rotating once per entry
// throughput: one insert per cycle unless the output stalls; a readout holds off new input
// reset: entry count, cell valid bits, state and output valid clear; stored data is not reset
`default_nettype none
`include "sorted_insert_priority_queue_macros.svh"
module sorted_insert_priority_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // tag [15:0], priority_req [31:16]
    input  wire logic [0:0]  s_axis_tuser,  // mode [0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // entry_tag [15:0], entry_priority [31:16]
    output logic [1:0]       m_axis_tuser,  // status [1:0]
    output logic             m_axis_tlast
);

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic                 state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    siq_pkg::entry_t      out_entry_reg, out_entry_next;
    logic [1:0]           out_stat_reg, out_stat_next;
    logic                 out_last_reg, out_last_next;

    siq_pkg::cell_ctrl_t  ctrl;
    siq_pkg::entry_t      ent [DEPTH];
    logic [DEPTH-1:0]     valid_vec;
    logic [DEPTH-1:0]     keep_vec;

    logic                 in_acc;
    logic                 out_free;
    logic                 full;
    logic                 read_last;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign full          = (count_reg == CW'(DEPTH));
    assign read_last     = (idx_reg == (count_reg - CW'(1)));

    assign ctrl.new_entry.tag  = s_axis_tdata[15:0];
    assign ctrl.new_entry.prio = s_axis_tdata[31:16];
    assign ctrl.ins = in_acc && (s_axis_tuser[0] == siq_pkg::MODE_INSERT) && !full;
    assign ctrl.rot = (state_reg == S_READ) && out_free;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic            lk, lv, rv;
            siq_pkg::entry_t le, re;
            if (gi == 0)
            begin : g_first
                assign lk = 1'b0;
                assign lv = 1'b1;
                assign le = ctrl.new_entry;
            end
            else
            begin : g_mid
                assign lk = keep_vec[gi-1];
                assign lv = valid_vec[gi-1];
                assign le = ent[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign rv = 1'b0;
                assign re = ent[gi];
            end
            else
            begin : g_inner
                assign rv = valid_vec[gi+1];
                assign re = ent[gi+1];
            end
            siq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_keep   (lk),
                .left_valid  (lv),
                .left_entry  (le),
                .right_valid (rv),
                .right_entry (re),
                .head_entry  (ent[0]),
                .keep        (keep_vec[gi]),
                .valid       (valid_vec[gi]),
                .entry       (ent[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_entry_next = out_entry_reg;
        out_stat_next  = out_stat_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    out_entry_next = '0;
                    out_last_next  = 1'b1;
                    if (s_axis_tuser[0] == siq_pkg::MODE_INSERT)
                    begin
                        out_valid_next = 1'b1;
                        if (full)
                        begin
                            out_stat_next = siq_pkg::ST_DROPPED;
                        end
                        else
                        begin
                            out_stat_next = siq_pkg::ST_INSERTED;
                            count_next    = count_reg + CW'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        out_stat_next  = siq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        state_next = S_READ;
                        idx_next   = '0;
                    end
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_entry_next = ent[0];
                    out_stat_next  = siq_pkg::ST_ENTRY;
                    out_last_next  = read_last;
                    idx_next       = idx_reg + CW'(1);
                    if (read_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_entry_reg <= out_entry_next;
        out_stat_reg  <= out_stat_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_entry_reg.prio, out_entry_reg.tag};
    assign m_axis_tuser  = out_stat_reg;
    assign m_axis_tlast  = out_last_reg;

    `SIQ_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CW'(DEPTH), "entry count above depth")
    `SIQ_ASSERT_NOW(a_valid_count, 1'b1, $countones(valid_vec) == 32'(count_reg),
        "cell valid bits disagree with entry count")
    `SIQ_ASSERT_NEXT(a_full_drop,
        in_acc && (s_axis_tuser[0] == siq_pkg::MODE_INSERT) && full,
        m_axis_tvalid && (m_axis_tuser == siq_pkg::ST_DROPPED) && $stable(count_reg),
        "insert into full queue not dropped")
    `SIQ_ASSERT_NOW(a_read_blocks, state_reg == S_READ, !s_axis_tready,
        "input taken during readout")

endmodule
`default_nettype wire

/* sim/tb.sv */
`default_nettype none
module tb;

    localparam int QUEUE_DEPTH = 16;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [siq_pkg::STAT_W-1:0]        status;
        logic [siq_pkg::TAG_W-1:0]         tag;
        logic signed [siq_pkg::PRIO_W-1:0] prio;
        logic                              last;
    } queue_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // tag [15:0], priority_req [31:16]
    logic [0:0]  s_axis_tuser;   // mode [0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // entry_tag [15:0], entry_priority [31:16]
    logic [1:0]  m_axis_tuser;   // status [1:0]
    logic        m_axis_tlast;

    // own copy of the sorted store
    logic [siq_pkg::TAG_W-1:0]         held_tag [QUEUE_DEPTH];
    logic signed [siq_pkg::PRIO_W-1:0] held_prio [QUEUE_DEPTH];
    int                                held_count;

    queue_result_t pending_results[$];
    int            fail_count;
    int            idle_cycles;
    int            tx_calm;
    int            rx_hold;
    int            rx_calm;

    sorted_insert_priority_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #10 clk = ~clk;

    function automatic void push_result(logic [siq_pkg::STAT_W-1:0] status,
                                        logic [siq_pkg::TAG_W-1:0] tag,
                                        logic signed [siq_pkg::PRIO_W-1:0] prio,
                                        logic last);
        queue_result_t r;
        r.status = status;
        r.tag    = tag;
        r.prio   = prio;
        r.last   = last;
        pending_results.push_back(r);
    endfunction

    // sorted insert (or drop when full) or full readout (or empty status), with the results it should give
    function automatic void predict_queue(logic mode, logic [siq_pkg::TAG_W-1:0] tag,
                                          logic signed [siq_pkg::PRIO_W-1:0] prio);
        int pos;
        if (mode == siq_pkg::MODE_INSERT)
        begin
            if (held_count >= QUEUE_DEPTH)
            begin
                push_result(siq_pkg::ST_DROPPED, '0, '0, 1'b1);
            end
            else
            begin
                pos = held_count;
                for (int i = 0; i < held_count; i++)
                begin
                    if (held_prio[i] < prio)
                    begin
                        pos = i;
                        break;
                    end
                end
                for (int i = held_count; i > pos; i--)
                begin
                    held_tag[i]  = held_tag[i-1];
                    held_prio[i] = held_prio[i-1];
                end
                held_tag[pos]  = tag;
                held_prio[pos] = prio;
                held_count++;
                push_result(siq_pkg::ST_INSERTED, '0, '0, 1'b1);
            end
        end
        else if (held_count == 0)
        begin
            push_result(siq_pkg::ST_EMPTY, '0, '0, 1'b1);
        end
        else
        begin
            for (int i = 0; i < held_count; i++)
                push_result(siq_pkg::ST_ENTRY, held_tag[i], held_prio[i], i == held_count - 1);
        end
    endfunction

    // mostly back to back, some short gaps, a few long ones, and calm stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm > 0)
        begin
            tx_calm--;
            return 0;
        end
        if (r < 5)
        begin
            tx_calm = $urandom_range(15, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // called at a rising edge; returns at the edge of the transfer with tvalid still high
    task automatic send_item(input logic mode, input logic [siq_pkg::TAG_W-1:0] tag,
                             input logic signed [siq_pkg::PRIO_W-1:0] prio);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {prio, tag};
        s_axis_tuser  <= mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_queue(mode, tag, prio);
    endtask

    task automatic check_empty_readout();
        send_item(siq_pkg::MODE_TRAVERSE, 16'h0000, 16'sh0000);
        send_item(siq_pkg::MODE_TRAVERSE, 16'hFFFF, 16'sh8000);
    endtask

    task automatic check_extreme_fields();
        send_item(siq_pkg::MODE_INSERT, 16'h0000, 16'sh0000);
        send_item(siq_pkg::MODE_INSERT, 16'hFFFF, 16'sh7FFF);
        send_item(siq_pkg::MODE_INSERT, 16'h5A5A, 16'sh8000);
        send_item(siq_pkg::MODE_INSERT, 16'hA5A5, 16'shFFFF);
        send_item(siq_pkg::MODE_INSERT, 16'h0001, 16'sh0001);
        send_item(siq_pkg::MODE_TRAVERSE, 16'h7FFF, 16'sh7FFF);
    endtask

    // equal priorities must come out in arrival order
    task automatic check_equal_priority_order();
        send_item(siq_pkg::MODE_INSERT, 16'h1111, 16'sh0000);
        send_item(siq_pkg::MODE_INSERT, 16'h2222, 16'sh7FFF);
        send_item(siq_pkg::MODE_INSERT, 16'h3333, 16'sh8000);
        send_item(siq_pkg::MODE_INSERT, 16'h4444, 16'sh0000);
        send_item(siq_pkg::MODE_TRAVERSE, 16'h0000, 16'sh0000);
    endtask

    task automatic run_random_mix(input int n_items);
        logic signed [siq_pkg::PRIO_W-1:0] prio;
        int r;
        for (int k = 0; k < n_items; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                prio = 16'($urandom);
            else if (r < 70)
                prio = 16'($signed($urandom_range(0, 4)) - 2);
            else if (r < 85 && held_count > 0)
                prio = held_prio[$urandom_range(0, held_count - 1)];
            else
                prio = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
            if ($urandom_range(0, 99) < 40)
                send_item(siq_pkg::MODE_TRAVERSE, 16'($urandom), 16'($urandom));
            else
                send_item(siq_pkg::MODE_INSERT, 16'($urandom), prio);
        end
    endtask

    task automatic check_full_drop();
        while (held_count < QUEUE_DEPTH)
            send_item(siq_pkg::MODE_INSERT, 16'($urandom), 16'($urandom));
        send_item(siq_pkg::MODE_INSERT, 16'hFFFF, 16'sh7FFF);
        send_item(siq_pkg::MODE_INSERT, 16'h0000, 16'sh8000);
        send_item(siq_pkg::MODE_TRAVERSE, 16'hFFFF, 16'shFFFF);
    endtask

    // receiver: ready most of the time, short and long holds, calm stretches
    always @(posedge clk)
    begin
        logic ready;
        int r;
        r = $urandom_range(0, 99);
        ready = 1'b1;
        if (rx_hold > 0)
        begin
            rx_hold--;
            ready = 1'b0;
        end
        else if (rx_calm > 0)
        begin
            rx_calm--;
        end
        else if (r < 8)
        begin
            rx_calm = $urandom_range(20, 80);
        end
        else if (r >= 70 && r < 95)
        begin
            rx_hold = $urandom_range(0, 3);
            ready = 1'b0;
        end
        else if (r >= 95)
        begin
            rx_hold = $urandom_range(8, 40);
            ready = 1'b0;
        end
        m_axis_tready <= ready;
    end

    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer: status %0d tdata %h", m_axis_tuser,
                       m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[15:0] !== want.tag)
                begin
                    $error("entry_tag: expected %h, got %h", want.tag, m_axis_tdata[15:0]);
                    fail_count++;
                end
                if (m_axis_tdata[31:16] !== want.prio)
                begin
                    $error("entry_priority: expected %0d, got %0d", want.prio,
                           $signed(m_axis_tdata[31:16]));
                    fail_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        held_count    = 0;
        tx_calm       = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_empty_readout();
        check_extreme_fields();
        check_equal_priority_order();
        run_random_mix(180);
        check_full_drop();

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
+incdir+sv
sv/siq_pkg.sv
sv/siq_cell.sv
sv/sorted_insert_priority_queue.sv
sim/tb.sv
